[design/dtsl_pkg.sv]
// ----------------------------------------------------------------------------
// dtsl_pkg
// Shared constants for the daily temperature slot logger: data and slot
// widths, temperature codes, report selector codes and the divide-by-six
// reciprocal.
// ----------------------------------------------------------------------------
package dtsl_pkg;

	localparam int DATA_W = 8;
	localparam int HOUR_W = 5;
	localparam int MIN_W  = 6;
	localparam int SEL_W  = 2;
	localparam int CD_W   = 3;

	// slot from raw clock fields reaches 320, so it needs nine bits
	localparam int SLOT_W = 9;
	// hour*60+minute from raw fields reaches 1923
	localparam int TOD_W  = 11;

	// floor(x/6) == (x*RECIP) >> RECIP_SH for x below 2**17
	localparam int RECIP_W  = 16;
	localparam int RECIP_SH = 18;
	localparam int PROD_W   = TOD_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = 16'hAAAB;

	localparam logic [DATA_W-1:0] TEMP_ERASED = 8'hFF;
	localparam logic [DATA_W-1:0] TEMP_ZERO_C = 8'(32 << 1);
	localparam logic [DATA_W-1:0] TEMP_FLOOR  = 8'h00;

	localparam logic [SEL_W-1:0] SEL_CURRENT = 2'd0;
	localparam logic [SEL_W-1:0] SEL_MIN     = 2'd1;
	localparam logic [SEL_W-1:0] SEL_MAX     = 2'd2;

endpackage

[design/daily_temperature_slot_logger.sv]
// ----------------------------------------------------------------------------
// daily_temperature_slot_logger
// Order: a current-value report passes S_SLOT, S_UPD, S_DONE to the result
//   word; a min/max report adds S_SCAN to last = min(slot, SLOT_COUNT-1),
//   reading the day store one entry per cycle through its read port.
// Throughput: one word at a time; next word taken once the result is loaded.
// Reset: countdown 1, last saved slot 0, current 0 C, day store all erased.
// ----------------------------------------------------------------------------
module daily_temperature_slot_logger #(
	parameter int SLOT_COUNT  = 240,
	parameter int POLL_PERIOD = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dtsl_pkg::HOUR_W-1:0]   hour,
	input  logic [dtsl_pkg::MIN_W-1:0]    minute,
	input  logic                          sensor_ready,
	input  logic [dtsl_pkg::DATA_W-1:0]   sensor_temp,
	input  logic [dtsl_pkg::SEL_W-1:0]    report_select,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dtsl_pkg::DATA_W-1:0]   reported_temp
);

	localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SLOT = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]                    state_q;

	logic [dtsl_pkg::HOUR_W-1:0]   hour_q;
	logic [dtsl_pkg::MIN_W-1:0]    minute_q;
	logic                          ready_q;
	logic [dtsl_pkg::DATA_W-1:0]   sample_q;
	logic [dtsl_pkg::SEL_W-1:0]    sel_q;

	logic [dtsl_pkg::CD_W-1:0]     countdown_q;
	logic [ADDR_W-1:0]             last_saved_q;
	logic [dtsl_pkg::DATA_W-1:0]   current_q;

	logic [dtsl_pkg::SLOT_W-1:0]   slot_s1;
	logic [ADDR_W-1:0]             scan_last_q;
	logic [ADDR_W-1:0]             issue_idx_q;
	logic                          issue_done_q;
	logic                          rd_pend_q;
	logic [dtsl_pkg::DATA_W-1:0]   lo_q;
	logic [dtsl_pkg::DATA_W-1:0]   hi_q;

	logic [dtsl_pkg::DATA_W-1:0]   out_data_q;
	logic                          out_valid_q;

	logic                          accept;
	logic [dtsl_pkg::CD_W-1:0]     cd_dec;
	logic                          poll;
	logic                          slot_in_range;
	logic                          wr_en;
	logic                          rd_en;
	logic [dtsl_pkg::DATA_W-1:0]   rd_data;
	logic [dtsl_pkg::DATA_W-1:0]   result;
	logic                          out_free;
	logic                          want_scan;

	dtsl_slot_calc u_slot (
		.clk     (clk),
		.hour    (hour_q),
		.minute  (minute_q),
		.slot_s1 (slot_s1)
	);

	dtsl_store #(
		.DEPTH  (SLOT_COUNT),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (slot_s1[ADDR_W-1:0]),
		.wr_data (sample_q),
		.rd_en   (rd_en),
		.rd_addr (issue_idx_q),
		.rd_data (rd_data)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign reported_temp = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign cd_dec        = countdown_q - dtsl_pkg::CD_W'(1);
	assign poll          = (cd_dec == '0);
	assign slot_in_range = (slot_s1 < dtsl_pkg::SLOT_W'(SLOT_COUNT));
	assign wr_en = (state_q == S_UPD) && poll && ready_q && slot_in_range
		&& (slot_s1 != dtsl_pkg::SLOT_W'(last_saved_q));
	assign rd_en = (state_q == S_SCAN) && !issue_done_q;
	assign want_scan = (sel_q == dtsl_pkg::SEL_MIN) || (sel_q == dtsl_pkg::SEL_MAX);

	always_comb begin
		priority if (sel_q == dtsl_pkg::SEL_MIN) begin
			result = lo_q;
		end else if (sel_q == dtsl_pkg::SEL_MAX) begin
			result = hi_q;
		end else begin
			result = current_q;
		end
	end

	// input word capture, scan end index and output data register
	always_ff @(posedge clk) begin
		if (accept) begin
			hour_q   <= hour;
			minute_q <= minute;
			ready_q  <= sensor_ready;
			sample_q <= sensor_temp;
			sel_q    <= report_select;
		end
		if (state_q == S_UPD) begin
			scan_last_q <= slot_in_range ? slot_s1[ADDR_W-1:0] : ADDR_W'(SLOT_COUNT - 1);
		end
		if (state_q == S_DONE && out_free) begin
			out_data_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			countdown_q  <= dtsl_pkg::CD_W'(1);
			last_saved_q <= '0;
			current_q    <= dtsl_pkg::TEMP_ZERO_C;
			issue_idx_q  <= '0;
			issue_done_q <= 1'b0;
			rd_pend_q    <= 1'b0;
			lo_q         <= dtsl_pkg::TEMP_ERASED;
			hi_q         <= dtsl_pkg::TEMP_FLOOR;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (poll) begin
						if (ready_q) begin
							countdown_q <= dtsl_pkg::CD_W'(1);
							current_q   <= sample_q;
						end else begin
							countdown_q <= dtsl_pkg::CD_W'(POLL_PERIOD);
						end
					end else begin
						countdown_q <= cd_dec;
					end
					if (wr_en) begin
						last_saved_q <= slot_s1[ADDR_W-1:0];
					end
					issue_idx_q  <= '0;
					issue_done_q <= 1'b0;
					rd_pend_q    <= 1'b0;
					lo_q         <= dtsl_pkg::TEMP_ERASED;
					hi_q         <= dtsl_pkg::TEMP_FLOOR;
					state_q      <= want_scan ? S_SCAN : S_DONE;
				end
				S_SCAN: begin
					rd_pend_q <= rd_en;
					// fold the entry read last cycle
					if (rd_pend_q) begin
						if (rd_data < lo_q) begin
							lo_q <= rd_data;
						end
						if (rd_data > hi_q) begin
							hi_q <= rd_data;
						end
					end
					if (rd_en) begin
						if (issue_idx_q == scan_last_q) begin
							issue_done_q <= 1'b1;
						end else begin
							issue_idx_q <= issue_idx_q + ADDR_W'(1);
						end
					end
					if (issue_done_q && !rd_pend_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[design/dtsl_slot_calc.sv]
// ----------------------------------------------------------------------------
// dtsl_slot_calc
// Turns hour and minute into a six-minute slot number: minute of day times
// a fixed reciprocal of six, result registered.
// ----------------------------------------------------------------------------
module dtsl_slot_calc (
	input  logic                          clk,
	input  logic [dtsl_pkg::HOUR_W-1:0]   hour,
	input  logic [dtsl_pkg::MIN_W-1:0]    minute,
	output logic [dtsl_pkg::SLOT_W-1:0]   slot_s1
);

	logic [dtsl_pkg::TOD_W-1:0]  tod;
	logic [dtsl_pkg::PROD_W-1:0] prod;

	// hour*60 as hour*64 - hour*4
	assign tod = ({hour, 6'b0} - {4'b0, hour, 2'b0}) + {5'b0, minute};
	assign prod = dtsl_pkg::PROD_W'(tod) * dtsl_pkg::PROD_W'(dtsl_pkg::RECIP);

	always_ff @(posedge clk) begin
		slot_s1 <= prod[dtsl_pkg::RECIP_SH +: dtsl_pkg::SLOT_W];
	end

endmodule

[design/dtsl_store.sv]
// ----------------------------------------------------------------------------
// dtsl_store
// Day store: one synchronous memory of temperature codes, one write and one
// read port, read data registered. Per-entry valid bits make unwritten
// entries read as erased right after reset.
// ----------------------------------------------------------------------------
module dtsl_store #(
	parameter int DEPTH  = 240,
	parameter int ADDR_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [ADDR_W-1:0]           wr_addr,
	input  logic [dtsl_pkg::DATA_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [ADDR_W-1:0]           rd_addr,
	output logic [dtsl_pkg::DATA_W-1:0] rd_data
);

	logic [dtsl_pkg::DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]            valid_q;
	logic [dtsl_pkg::DATA_W-1:0] rd_data_q;
	logic                        rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : dtsl_pkg::TEMP_ERASED;

endmodule

[bench/tb_daily_temperature_slot_logger.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_daily_temperature_slot_logger
// Sends ticks to the logger and checks every reported temperature
// against a cycle-free predictor of the poll countdown, the day store and the
// min/max scan. Covers reset values, edge clock values, polls with and
// without a ready sample, random day walks, random noise and a long output
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_daily_temperature_slot_logger;

	localparam int SLOTS = 240;
	localparam int POLL  = 7;
	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [dtsl_pkg::SEL_W-1:0] SEL_UNUSED = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [dtsl_pkg::HOUR_W-1:0]   hour = '0;
	logic [dtsl_pkg::MIN_W-1:0]    minute = '0;
	logic                          sensor_ready = 1'b0;
	logic [dtsl_pkg::DATA_W-1:0]   sensor_temp = '0;
	logic [dtsl_pkg::SEL_W-1:0]    report_select = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [dtsl_pkg::DATA_W-1:0]   reported_temp;

	// predictor state
	logic [dtsl_pkg::CD_W-1:0]     pred_countdown;
	logic [dtsl_pkg::DATA_W-1:0]   pred_last_slot;
	logic [dtsl_pkg::DATA_W-1:0]   pred_current;
	logic [dtsl_pkg::DATA_W-1:0]   pred_day [SLOTS];

	logic [dtsl_pkg::DATA_W-1:0]   expected_reports [$];
	logic [dtsl_pkg::DATA_W-1:0]   want_word;
	int unsigned                   mismatches = 0;
	bit                            idle_on = 1'b1;
	int unsigned                   hold_off_req = 0;
	bit                            hold_taken = 1'b0;
	int unsigned                   stall_left = 0;

	daily_temperature_slot_logger #(
		.SLOT_COUNT  (SLOTS),
		.POLL_PERIOD (POLL)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.hour          (hour),
		.minute        (minute),
		.sensor_ready  (sensor_ready),
		.sensor_temp   (sensor_temp),
		.report_select (report_select),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reported_temp (reported_temp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// advance the countdown, log a polled sample and compute the report
	task automatic log_and_report(input logic [dtsl_pkg::HOUR_W-1:0] h,
			input logic [dtsl_pkg::MIN_W-1:0] m, input logic rdy,
			input logic [dtsl_pkg::DATA_W-1:0] t, input logic [dtsl_pkg::SEL_W-1:0] s);
		int unsigned slot;
		int unsigned last;
		logic [dtsl_pkg::DATA_W-1:0] lo;
		logic [dtsl_pkg::DATA_W-1:0] hi;
		logic [dtsl_pkg::DATA_W-1:0] rep;
		slot = (int'(h) * 60 + int'(m)) / 6;
		pred_countdown = pred_countdown - 1'b1;
		if (pred_countdown == '0) begin
			pred_countdown = dtsl_pkg::CD_W'(POLL);
			if (rdy) begin
				if (slot < SLOTS && slot != int'(pred_last_slot)) begin
					pred_last_slot = dtsl_pkg::DATA_W'(slot);
					pred_day[IDX_W'(slot)] = t;
				end
				pred_countdown = dtsl_pkg::CD_W'(1);
				pred_current = t;
			end
		end
		last = (slot > SLOTS - 1) ? SLOTS - 1 : slot;
		lo = dtsl_pkg::TEMP_ERASED;
		hi = dtsl_pkg::TEMP_FLOOR;
		for (int unsigned i = 0; i <= last; i++) begin
			if (pred_day[IDX_W'(i)] < lo)
				lo = pred_day[IDX_W'(i)];
			if (pred_day[IDX_W'(i)] > hi)
				hi = pred_day[IDX_W'(i)];
		end
		case (s)
			dtsl_pkg::SEL_MIN: rep = lo;
			dtsl_pkg::SEL_MAX: rep = hi;
			default: rep = pred_current;
		endcase
		expected_reports.push_back(rep);
	endtask

	task automatic send_tick(input logic [dtsl_pkg::HOUR_W-1:0] h,
			input logic [dtsl_pkg::MIN_W-1:0] m, input logic rdy,
			input logic [dtsl_pkg::DATA_W-1:0] t, input logic [dtsl_pkg::SEL_W-1:0] s);
		int unsigned gap;
		gap = idle_on ? rand_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hour          <= h;
		minute        <= m;
		sensor_ready  <= rdy;
		sensor_temp   <= t;
		report_select <= s;
		in_valid      <= 1'b1;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		log_and_report(h, m, rdy, t, s);
	endtask

	task automatic flag_error(input string what, input logic [dtsl_pkg::DATA_W-1:0] want,
			input logic [dtsl_pkg::DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected %02h, got %02h", $realtime, what, want, got);
	endtask

	// result side: random stalls, plus a counted hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req > 0 && !hold_taken) begin
				stall_left = hold_off_req;
				hold_taken = 1'b1;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				stall_left = rand_gap();
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// compare each taken result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_reports.size() == 0) begin
				flag_error("unexpected word", '0, reported_temp);
			end else begin
				want_word = expected_reports.pop_front();
				if (reported_temp !== want_word)
					flag_error("reported_temp", want_word, reported_temp);
			end
		end
	end

	task automatic test_directed();
		// reset values: first tick polls with nothing ready
		send_tick(5'd5, 6'd0, 1'b0, 8'h00, dtsl_pkg::SEL_CURRENT);
		send_tick(5'd5, 6'd0, 1'b1, 8'hAA, dtsl_pkg::SEL_MIN);
		send_tick(5'd5, 6'd0, 1'b1, 8'h00, dtsl_pkg::SEL_MAX);
		send_tick(5'd0, 6'd0, 1'b1, 8'h00, SEL_UNUSED);
		send_tick(5'd23, 6'd59, 1'b0, 8'h55, dtsl_pkg::SEL_MIN);
		send_tick(5'd31, 6'd63, 1'b1, 8'h77, dtsl_pkg::SEL_MAX);
		send_tick(5'd12, 6'd0, 1'b1, 8'h11, dtsl_pkg::SEL_CURRENT);
		// poll hits slot 0, which equals the last saved slot: no write
		send_tick(5'd0, 6'd0, 1'b1, 8'h00, dtsl_pkg::SEL_CURRENT);
		send_tick(5'd0, 6'd3, 1'b1, 8'hFF, dtsl_pkg::SEL_MIN);
		send_tick(5'd0, 6'd6, 1'b1, 8'h00, dtsl_pkg::SEL_MIN);
		send_tick(5'd0, 6'd12, 1'b1, 8'hFF, dtsl_pkg::SEL_MAX);
		send_tick(5'd23, 6'd54, 1'b1, 8'h80, dtsl_pkg::SEL_MIN);
		send_tick(5'd23, 6'd59, 1'b1, 8'h01, dtsl_pkg::SEL_MAX);
		// clock out of range: sample goes current only, scan clamps
		send_tick(5'd24, 6'd0, 1'b1, 8'h02, dtsl_pkg::SEL_MIN);
		send_tick(5'd31, 6'd63, 1'b1, 8'h03, SEL_UNUSED);
		send_tick(5'd0, 6'd6, 1'b1, 8'h7F, dtsl_pkg::SEL_MIN);
		send_tick(5'd0, 6'd0, 1'b1, 8'h40, dtsl_pkg::SEL_MAX);
		send_tick(5'd0, 6'd0, 1'b1, 8'h41, dtsl_pkg::SEL_MIN);
		send_tick(5'd12, 6'd30, 1'b0, 8'h42, dtsl_pkg::SEL_CURRENT);
		send_tick(5'd12, 6'd30, 1'b1, 8'hC3, dtsl_pkg::SEL_MAX);
		send_tick(5'd0, 6'd59, 1'b1, 8'h3C, dtsl_pkg::SEL_MIN);
		send_tick(5'd16, 6'd32, 1'b1, 8'h5A, dtsl_pkg::SEL_MAX);
	endtask

	// well-formed days: time moves forward, samples drift
	task automatic test_day_walk(input int unsigned ticks);
		int unsigned n;
		int unsigned run;
		int unsigned r;
		int mm;
		int hh;
		logic [dtsl_pkg::DATA_W-1:0] t;
		n = 0;
		while (n < ticks) begin
			if ($urandom_range(0, 3) == 0) begin
				hh = 0;
				mm = 0;
			end else begin
				hh = $urandom_range(0, 23);
				mm = $urandom_range(0, 59);
			end
			t = dtsl_pkg::DATA_W'($urandom_range(40, 120));
			run = $urandom_range(30, 200);
			if (run > ticks - n)
				run = ticks - n;
			idle_on = ($urandom_range(0, 3) != 0);
			repeat (run) begin
				r = $urandom_range(0, 99);
				if (r >= 95)
					mm += $urandom_range(7, 40);
				else if (r >= 70)
					mm += $urandom_range(1, 6);
				while (mm >= 60) begin
					mm -= 60;
					hh = (hh == 23) ? 0 : hh + 1;
				end
				case ($urandom_range(0, 19))
					0: t = dtsl_pkg::TEMP_FLOOR;
					1: t = dtsl_pkg::TEMP_ERASED;
					default: t = t + dtsl_pkg::DATA_W'($urandom_range(0, 6))
						- dtsl_pkg::DATA_W'(3);
				endcase
				send_tick(dtsl_pkg::HOUR_W'(hh), dtsl_pkg::MIN_W'(mm),
					$urandom_range(0, 9) < 8, t,
					dtsl_pkg::SEL_W'($urandom_range(0, 3)));
				n++;
			end
		end
		idle_on = 1'b1;
	endtask

	task automatic test_noise(input int unsigned ticks);
		repeat (ticks) begin
			send_tick(dtsl_pkg::HOUR_W'($urandom_range(0, 31)),
				dtsl_pkg::MIN_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
				dtsl_pkg::DATA_W'($urandom), dtsl_pkg::SEL_W'($urandom_range(0, 3)));
		end
	endtask

	// hold the result side off while ticks keep coming
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_off_req = 1500;
		repeat (12) begin
			send_tick(dtsl_pkg::HOUR_W'($urandom_range(0, 2)),
				dtsl_pkg::MIN_W'($urandom_range(0, 59)), 1'($urandom_range(0, 1)),
				dtsl_pkg::DATA_W'($urandom), dtsl_pkg::SEL_W'($urandom_range(0, 3)));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int unsigned waited;
		pred_countdown = dtsl_pkg::CD_W'(1);
		pred_last_slot = '0;
		pred_current = dtsl_pkg::TEMP_ZERO_C;
		for (int i = 0; i < SLOTS; i++)
			pred_day[IDX_W'(i)] = dtsl_pkg::TEMP_ERASED;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_day_walk(800);
		test_backpressure();
		test_noise(400);
		test_day_walk(700);
		in_valid <= 1'b0;

		waited = 0;
		while (expected_reports.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("** daily_temperature_slot_logger: PASSED **");
		else
			$display("** daily_temperature_slot_logger: FAILED **");
		$finish;
	end

	initial begin
		#8000000;
		$display("** daily_temperature_slot_logger: FAILED **");
		$finish;
	end

endmodule

[daily_temperature_slot_logger.f]
design/dtsl_pkg.sv
design/dtsl_slot_calc.sv
design/dtsl_store.sv
design/daily_temperature_slot_logger.sv
bench/tb_daily_temperature_slot_logger.sv
